### design/assert_macros.svh
// Assertion macros for the RTL in this folder.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/ssq_pkg.sv
// Package for the stable sorted priority queue: default sizes, action and status codes.
// Depends on nothing; used by the top level.
package ssq_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int TAG_BITS_DEF  = 16;
    localparam int PRIO_BITS_DEF = 16;

    // Result status codes
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    // Action codes carried on the input tuser
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

endpackage

### design/stable_sorted_priority_queue_unit.sv
// Stable sorted priority queue: each input word is an enqueue (tag, priority) or a dequeue,
// and each gives exactly one result word (status, removed tag and priority, occupancy).
// The lowest priority leaves first and equal priorities leave in arrival order. Entries sit
// sorted in one RAM used as a ring (head pointer, tail pointer). A dequeue reads the head and
// its result word goes through S_DEQ and S_DONE into the result register; a dropped enqueue
// (full), an ignored dequeue (empty) or an enqueue into an empty store goes straight to S_DONE.
// Any other enqueue walks back from the tail one entry per cycle in S_ENQ, moving each entry
// of higher priority up by one slot through the RAM's read and write ports; it walks over the
// held entries of strictly higher priority value. One word is in work at a time and the next
// is taken the cycle after the result is registered; the result register lets it in while a
// result waits, and a finished word only holds while that register is still full.
// No clearing pass is needed after reset. Depends on ssq_pkg, ssq_ram, assert_macros.svh.
`include "assert_macros.svh"

module stable_sorted_priority_queue_unit #(
    parameter int DEPTH     = ssq_pkg::DEPTH_DEF,
    parameter int TAG_BITS  = ssq_pkg::TAG_BITS_DEF,
    parameter int PRIO_BITS = ssq_pkg::PRIO_BITS_DEF,
    localparam int CW       = $clog2(DEPTH + 1),
    localparam int IN_W     = ((TAG_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((TAG_BITS + PRIO_BITS + CW + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [IN_W-1:0]                 i_s_axis_tdata,  // tag, priority_req
    input  logic                            i_s_axis_tuser,  // action
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [OUT_W-1:0]                o_m_axis_tdata,  // removed_tag, removed_priority,
                                                             // occupancy
    output logic [ssq_pkg::STATUS_BITS-1:0] o_m_axis_tuser   // status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = TAG_BITS + PRIO_BITS;
    localparam int SW    = CW + 1;

    // State codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_DEQ  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Ring pointer steps
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
    endfunction

    // Control registers
    logic [2:0]    r_state,    n_state;
    logic [AW-1:0] r_head,     n_head;
    logic [AW-1:0] r_tail,     n_tail;
    logic [CW-1:0] r_count,    n_count;
    logic [AW-1:0] r_addr,     n_addr;
    logic [CW-1:0] r_scan,     n_scan;
    logic          r_out_valid, n_out_valid;

    // Payload registers
    logic [TAG_BITS-1:0]             r_new_tag,    n_new_tag;
    logic [PRIO_BITS-1:0]            r_new_prio,   n_new_prio;
    logic [ssq_pkg::STATUS_BITS-1:0] r_res_status, n_res_status;
    logic [TAG_BITS-1:0]             r_res_tag,    n_res_tag;
    logic [PRIO_BITS-1:0]            r_res_prio,   n_res_prio;
    logic [ssq_pkg::STATUS_BITS-1:0] r_out_status, n_out_status;
    logic [TAG_BITS-1:0]             r_out_tag,    n_out_tag;
    logic [PRIO_BITS-1:0]            r_out_prio,   n_out_prio;
    logic [CW-1:0]                   r_out_occ,    n_out_occ;

    // RAM port signals
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [ENT_W-1:0] w_rd_data;

    logic                 w_accept;
    logic [TAG_BITS-1:0]  w_in_tag;
    logic [PRIO_BITS-1:0] w_in_prio;
    logic [PRIO_BITS-1:0] w_rd_prio;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_in_tag        = i_s_axis_tdata[TAG_BITS-1:0];
    assign w_in_prio       = i_s_axis_tdata[ENT_W-1:TAG_BITS];
    assign w_rd_prio       = w_rd_data[PRIO_BITS-1:0];

    // Entry store: {tag, priority}, priority in the low bits
    ssq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: accept, walk back from the tail shifting entries or read the head, then post the result
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_addr       = r_addr;
        n_scan       = r_scan;
        n_new_tag    = r_new_tag;
        n_new_prio   = r_new_prio;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_res_prio   = r_res_prio;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_prio   = r_out_prio;
        n_out_occ    = r_out_occ;
        n_out_valid  = r_out_valid;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_addr;
        w_wr_data    = {r_new_tag, r_new_prio};
        w_rd_en      = 1'b0;
        w_rd_addr    = r_addr;

        // result word taken downstream
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_new_tag    = w_in_tag;
                    n_new_prio   = w_in_prio;
                    n_res_status = ssq_pkg::STATUS_DONE;
                    n_res_tag    = '0;
                    n_res_prio   = '0;
                    if (i_s_axis_tuser == ssq_pkg::ACT_ENQ) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_status = ssq_pkg::STATUS_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            // empty store: new entry goes straight to the head slot
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_tail;
                            w_wr_data = {w_in_tag, w_in_prio};
                            n_tail    = ptr_inc(r_tail);
                            n_count   = r_count + 1'b1;
                            n_state   = S_DONE;
                        end else begin
                            // start the walk at the last held entry
                            w_rd_en   = 1'b1;
                            w_rd_addr = ptr_dec(r_tail);
                            n_addr    = ptr_dec(r_tail);
                            n_scan    = r_count;
                            n_state   = S_ENQ;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ssq_pkg::STATUS_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = r_head;
                            n_state   = S_DEQ;
                        end
                    end
                end
            end

            S_ENQ: begin
                // read data belongs to r_addr
                w_wr_en   = 1'b1;
                w_wr_addr = ptr_inc(r_addr);
                if (w_rd_prio > r_new_prio) begin
                    // held entry moves up one slot
                    w_wr_data = w_rd_data;
                    if (r_scan == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = ptr_dec(r_addr);
                        n_addr    = ptr_dec(r_addr);
                        n_scan    = r_scan - 1'b1;
                    end
                end else begin
                    // new entry lands behind every entry of lower or equal priority
                    n_tail  = ptr_inc(r_tail);
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end

            S_PUT: begin
                // every held entry had higher priority value: new entry becomes the head
                w_wr_en   = 1'b1;
                w_wr_addr = r_addr;
                n_tail    = ptr_inc(r_tail);
                n_count   = r_count + 1'b1;
                n_state   = S_DONE;
            end

            S_DEQ: begin
                n_res_tag  = w_rd_data[ENT_W-1:PRIO_BITS];
                n_res_prio = w_rd_prio;
                n_head     = ptr_inc(r_head);
                n_count    = r_count - 1'b1;
                n_state    = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_status = r_res_status;
                    n_out_tag    = r_res_tag;
                    n_out_prio   = r_res_prio;
                    n_out_occ    = r_count;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_addr      <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_new_tag    <= n_new_tag;
        r_new_prio   <= n_new_prio;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_res_prio   <= n_res_prio;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
        r_out_prio   <= n_out_prio;
        r_out_occ    <= n_out_occ;
    end

    // Result word packing
    always_comb begin
        o_m_axis_tdata                              = '0;
        o_m_axis_tdata[TAG_BITS-1:0]                = r_out_tag;
        o_m_axis_tdata[ENT_W-1:TAG_BITS]            = r_out_prio;
        o_m_axis_tdata[ENT_W+CW-1:ENT_W]            = r_out_occ;
    end
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tvalid = r_out_valid;

    // Ring consistency: tail sits count slots past head
    logic [SW-1:0] w_ring_sum;
    logic [SW-1:0] w_ring_wrap;
    assign w_ring_sum  = SW'(r_head) + SW'(r_count);
    assign w_ring_wrap = (w_ring_sum >= SW'(DEPTH)) ? w_ring_sum - SW'(DEPTH) : w_ring_sum;

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `ASSERT_SAME(a_ring_tail, i_clk, i_rst_n, 1'b1, AW'(w_ring_wrap) == r_tail)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, r_state != S_IDLE)
    `ASSERT_SAME(a_walk_in_range, i_clk, i_rst_n, r_state == S_ENQ,
                 (r_scan != '0) && (r_scan <= r_count))

endmodule

### design/ssq_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// Depends on nothing.
module ssq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sim/tb_stable_sorted_priority_queue_unit.sv
// Self-checking testbench for stable_sorted_priority_queue_unit: a directed table, then bursts
// of random enqueue and dequeue words, each result checked against pinned values or a behavioural queue model.
// Depends on ssq_pkg and the RTL of the unit; reads no files.
module tb_stable_sorted_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = ssq_pkg::DEPTH_DEF;
    localparam int TAG_BITS   = ssq_pkg::TAG_BITS_DEF;
    localparam int PRIO_BITS  = ssq_pkg::PRIO_BITS_DEF;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int IN_W       = ((TAG_BITS + PRIO_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((TAG_BITS + PRIO_BITS + CW + 7) / 8) * 8;
    localparam int RAND_WORDS = 1100;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 24;
    localparam int DIR_ROWS   = 24;

    // Codes from the package
    localparam int STATUS_BITS = ssq_pkg::STATUS_BITS;
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = ssq_pkg::STATUS_DONE;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = ssq_pkg::STATUS_FULL;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = ssq_pkg::STATUS_EMPTY;
    localparam logic ACT_ENQ = ssq_pkg::ACT_ENQ;
    localparam logic ACT_DEQ = ssq_pkg::ACT_DEQ;

    // One result word as the unit returns it
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_BITS-1:0]    rtag;
        logic [PRIO_BITS-1:0]   rprio;
        logic [CW-1:0]          occ;
    } t_queue_result;

    // Directed stimulus row; want_* only used where pinned is set
    typedef struct packed {
        logic                   action;
        logic [TAG_BITS-1:0]    tag;
        logic [PRIO_BITS-1:0]   prio;
        logic                   pinned;
        logic [STATUS_BITS-1:0] want_status;
        logic [TAG_BITS-1:0]    want_tag;
        logic [PRIO_BITS-1:0]   want_prio;
        logic [CW-1:0]          want_occ;
    } t_stim_row;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_traffic_mix;
    typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} t_rx_style;

    logic             clk;
    logic             rst_n   = 1'b0;
    logic             s_valid = 1'b0;
    logic [IN_W-1:0]  s_data  = '0;
    logic             s_user  = ACT_ENQ;
    logic             m_ready = 1'b0;
    logic             s_ready;
    logic             m_valid;
    logic [OUT_W-1:0] m_data;
    logic [STATUS_BITS-1:0] m_user;

    // Behavioural copy of the sorted store
    logic [TAG_BITS-1:0]  held_tag  [DEPTH];
    logic [PRIO_BITS-1:0] held_prio [DEPTH];
    int                   held_count = 0;

    t_queue_result expected_results[$];
    t_stim_row     dir_table [DIR_ROWS];
    int            fail_count  = 0;
    int            idle_cycles = 0;
    int            burst_left  = 0;

    stable_sorted_priority_queue_unit #(
        .DEPTH     (DEPTH),
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // tag, priority_req
        .i_s_axis_tuser  (s_user),   // action
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // removed_tag, removed_priority, occupancy
        .o_m_axis_tuser  (m_user)    // status
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one word to the store model and return the result it should give
    function automatic t_queue_result serve_word(input logic act,
                                                 input logic [TAG_BITS-1:0] tg,
                                                 input logic [PRIO_BITS-1:0] pr);
        t_queue_result r;
        int pos;
        int i;
        r.status = STATUS_DONE;
        r.rtag   = '0;
        r.rprio  = '0;
        if (act == ACT_ENQ) begin
            if (held_count >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                // new entry goes behind every entry of lower or equal priority
                pos = 0;
                while (pos < held_count && held_prio[pos] <= pr)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_tag[i]  = held_tag[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_tag[pos]  = tg;
                held_prio[pos] = pr;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            r.rtag  = held_tag[0];
            r.rprio = held_prio[0];
            for (i = 1; i < held_count; i++) begin
                held_tag[i-1]  = held_tag[i];
                held_prio[i-1] = held_prio[i];
            end
            held_count--;
        end
        r.occ = held_count[CW-1:0];
        return r;
    endfunction

    // Offer one word, with the sender's burst gaps, and log its expected result once taken
    task automatic drive_word(input logic act, input logic [TAG_BITS-1:0] tg,
                              input logic [PRIO_BITS-1:0] pr, input logic pinned,
                              input t_queue_result pinned_res);
        t_queue_result predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= {pr, tg};
        do @(posedge clk); while (s_ready !== 1'b1);
        predicted = serve_word(act, tg, pr);
        expected_results.insert(expected_results.size(), pinned ? pinned_res : predicted);
    endtask

    task automatic note_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        fail_count++;
        $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    // Receiver: changes its stall style every so often
    always @(posedge clk) begin : rx_pacing
        static t_rx_style rx_style = RX_OPEN;
        static int style_left = 0;
        static int stall_left = 0;
        if (style_left == 0) begin
            rx_style   = t_rx_style'($urandom_range(0, 2));
            style_left = $urandom_range(50, 200);
        end else begin
            style_left--;
        end
        case (rx_style)
            RX_OPEN: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 25);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Result checking and progress count
    always @(posedge clk) begin : check_results
        t_queue_result got;
        t_queue_result want;
        logic          moved;
        if (rst_n) begin
            moved = s_valid && (s_ready === 1'b1);
            if (m_valid === 1'b1 && m_ready) begin
                moved     = 1'b1;
                got.status = m_user;
                got.rtag   = m_data[TAG_BITS-1:0];
                got.rprio  = m_data[TAG_BITS +: PRIO_BITS];
                got.occ    = m_data[TAG_BITS + PRIO_BITS +: CW];
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result word, status", 0, got.status);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.rtag !== want.rtag)
                        note_mismatch("removed_tag", want.rtag, got.rtag);
                    if (got.rprio !== want.rprio)
                        note_mismatch("removed_priority", want.rprio, got.rprio);
                    if (got.occ !== want.occ)
                        note_mismatch("occupancy", want.occ, got.occ);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on a stalled run
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("tb_stable_sorted_priority_queue_unit failed");
        $finish;
    end

    initial begin : stimulus
        t_queue_result pinned_res;
        t_traffic_mix  mix;
        int            mix_left;
        int            enq_pct;
        int            k;
        logic          act;
        logic [TAG_BITS-1:0]  tg;
        logic [PRIO_BITS-1:0] pr;

        // empty dequeue, extremes, equal-priority order, fill to full and overflow, then two dequeues
        dir_table = '{
            '{ACT_DEQ, 16'h1234, 16'hABCD, 1'b1, STATUS_EMPTY, 16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'hFFFF, 16'hFFFF, 1'b1, STATUS_DONE,  16'h0000, 16'h0000, 5'd1},
            '{ACT_ENQ, 16'h0000, 16'h0000, 1'b1, STATUS_DONE,  16'h0000, 16'h0000, 5'd2},
            '{ACT_ENQ, 16'h0001, 16'h0000, 1'b1, STATUS_DONE,  16'h0000, 16'h0000, 5'd3},
            '{ACT_ENQ, 16'hA5A5, 16'h8000, 1'b1, STATUS_DONE,  16'h0000, 16'h0000, 5'd4},
            '{ACT_DEQ, 16'hFFFF, 16'hFFFF, 1'b1, STATUS_DONE,  16'h0000, 16'h0000, 5'd3},
            '{ACT_DEQ, 16'h0000, 16'h0000, 1'b1, STATUS_DONE,  16'h0001, 16'h0000, 5'd2},
            '{ACT_ENQ, 16'h5A5A, 16'hFFFF, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0100, 16'h8000, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0200, 16'h0001, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0300, 16'h7FFF, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0400, 16'h0001, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0500, 16'hFFFE, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0600, 16'h0000, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0700, 16'h8000, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0800, 16'h4000, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0900, 16'h0002, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0A00, 16'hC000, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0B00, 16'h0000, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0C00, 16'hFFFF, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'h0D00, 16'h1234, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_ENQ, 16'hFFFF, 16'h0000, 1'b1, STATUS_FULL,  16'h0000, 16'h0000, 5'd16},
            '{ACT_DEQ, 16'h5555, 16'hAAAA, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0},
            '{ACT_DEQ, 16'hAAAA, 16'h5555, 1'b0, STATUS_DONE,  16'h0000, 16'h0000, 5'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < DIR_ROWS; k++) begin
            pinned_res.status = dir_table[k].want_status;
            pinned_res.rtag   = dir_table[k].want_tag;
            pinned_res.rprio  = dir_table[k].want_prio;
            pinned_res.occ    = dir_table[k].want_occ;
            drive_word(dir_table[k].action, dir_table[k].tag, dir_table[k].prio,
                       dir_table[k].pinned, pinned_res);
        end

        // random traffic in segments that lean towards filling, draining or neither
        mix      = MIX_EVEN;
        mix_left = 0;
        for (k = 0; k < RAND_WORDS; k++) begin
            if (mix_left == 0) begin
                mix      = t_traffic_mix'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 80);
            end
            mix_left--;
            case (mix)
                MIX_FILL:  enq_pct = 85;
                MIX_DRAIN: enq_pct = 15;
                default:   enq_pct = 50;
            endcase
            act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
            tg  = TAG_BITS'($urandom);
            // narrow ranges give many equal priorities
            case ($urandom_range(0, 9))
                0, 1, 2, 3: pr = PRIO_BITS'($urandom_range(0, 3));
                4, 5:       pr = PRIO_BITS'($urandom);
                6, 7: begin
                    case ($urandom_range(0, 3))
                        0:       pr = '0;
                        1:       pr = 16'd1;
                        2:       pr = 16'hFFFE;
                        default: pr = '1;
                    endcase
                end
                default:    pr = PRIO_BITS'($urandom_range(0, 255));
            endcase
            drive_word(act, tg, pr, 1'b0, pinned_res);
        end
        s_valid <= 1'b0;

        // drain, then allow for a late stray word
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("tb_stable_sorted_priority_queue_unit passed");
        else
            $display("tb_stable_sorted_priority_queue_unit failed");
        $finish;
    end

endmodule
